### design/bcm_pkg.sv
package bcm_pkg;
  localparam int MAX_SLOTS  = 16;
  localparam int MAX_TARGET = 1023;
  localparam int MAX_STOCK  = 255;
  localparam int SLOT_W  = 4;
  localparam int VAL_W   = 10;
  localparam int STK_W   = 8;
  localparam int TGT_W   = 10;
  localparam int CNT_W   = 13;
  localparam int TOT_W   = 12;
  localparam int NSL_W   = 5;
  localparam int ROW_W   = 5;
  localparam int ADDR_W  = ROW_W + TGT_W;
  localparam logic [CNT_W-1:0] NO_SOL = {CNT_W{1'b1}};
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  typedef struct packed {
    logic              command;
    logic [SLOT_W-1:0] slot_index;
    logic [VAL_W-1:0]  coin_value;
    logic [STK_W-1:0]  coin_stock;
    logic [TGT_W-1:0]  target_amount;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] result_slot;
    logic [STK_W-1:0]  used_count;
    logic [TOT_W-1:0]  total_coins;
    logic              last;
  } out_word_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;        // write slot from input word
    logic start;       // latch target and slot count
    logic init_row;    // write base row entry t
    logic cell_init;   // begin cell at (i,t)
    logic k_step;      // evaluate next k
    logic cell_write;  // store best of cell
    logic t_next;
    logic i_next;
    logic rd_total;
    logic rb_init;     // start rebuild of slot i, read need
    logic rb_need;     // latch need, read first k
    logic rb_read;     // read entry for current k
    logic rb_step;     // evaluate current k
    logic rb_done;     // commit pick
  } cmd_t;

  typedef struct packed {
    logic t_last;      // t == target
    logic i_zero;
    logic k_done;      // cell search finished
    logic rb_hit;      // rebuild search finished
    logic rb_last;     // i == n-1
    logic no_sol;
    logic empty;       // no slots in use
    logic tgt_zero;
  } sts_t;
endpackage

### design/bcm_if.sv
interface bcm_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/bcm_datapath.sv
module bcm_datapath (
  input  logic                     clk,
  input  bcm_pkg::cmd_t            cmd,
  input  bcm_pkg::in_word_t        in_word,
  input  logic [bcm_pkg::NSL_W-1:0] slots_in_use,
  output bcm_pkg::sts_t            sts,
  output bcm_pkg::out_word_t       res
);
  import bcm_pkg::*;

  logic [VAL_W-1:0] slot_values [MAX_SLOTS];
  logic [STK_W-1:0] slot_stocks [MAX_SLOTS];
  logic [CNT_W-1:0] table_mem [(MAX_SLOTS+1)*(MAX_TARGET+1)];

  logic [TGT_W-1:0] target, t, rem;
  logic [ROW_W-1:0] n, i;
  logic [STK_W:0]   k;
  logic [TGT_W:0]   used;
  logic [CNT_W-1:0] best, need, rdata, tot_q, cand;
  logic [VAL_W-1:0] v;
  logic [STK_W-1:0] s, pick;
  logic [STK_W+VAL_W-1:0] pick_amt;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [CNT_W-1:0] wdata;
  logic             we, tot_rd;
  logic [NSL_W-1:0] n_sat;

  assign n_sat = (slots_in_use > NSL_W'(MAX_SLOTS)) ? NSL_W'(MAX_SLOTS) : slots_in_use;

  assign v = slot_values[i[SLOT_W-1:0]];
  assign s = slot_stocks[i[SLOT_W-1:0]];

  assign cand = rdata + CNT_W'(k);
  assign pick_amt = pick * v;

  always_comb begin
    we = 1'b0;
    waddr = {n, t};
    wdata = (t == '0) ? '0 : NO_SOL;
    if (cmd.init_row) begin
      we = 1'b1;
    end else if (cmd.cell_write) begin
      we = 1'b1;
      waddr = {i, t};
      wdata = best;
    end
  end

  // read address: cell search reads row i+1 at t-used, rebuild same with rem
  always_comb begin
    raddr = {ROW_W'(i + 1'b1), TGT_W'(t - used[TGT_W-1:0])};
    if (cmd.rb_need || cmd.rb_read)
      raddr = {ROW_W'(i + 1'b1), TGT_W'(rem - used[TGT_W-1:0])};
    if (cmd.rb_init)
      raddr = {i, rem};
    if (cmd.rd_total)
      raddr = {ROW_W'(0), target};
  end

  always_ff @(posedge clk) begin
    if (we) table_mem[waddr] <= wdata;
    rdata <= table_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_values[in_word.slot_index] <= in_word.coin_value;
      slot_stocks[in_word.slot_index] <= in_word.coin_stock;
    end
    if (cmd.start) begin
      target <= in_word.target_amount;
      n <= ROW_W'(n_sat);
      i <= ROW_W'(n_sat) - 1'b1;
      t <= '0;
    end
    if (cmd.init_row) t <= (t == target) ? '0 : t + 1'b1;
    if (cmd.t_next) t <= t + 1'b1;
    if (cmd.i_next) begin
      i <= i - 1'b1;
      t <= '0;
    end
    if (cmd.cell_init) begin
      k <= '0;
      used <= '0;
      best <= NO_SOL;
    end
    if (cmd.k_step) begin
      // rdata holds row i+1 at t - (k*v) for current k
      if (rdata != NO_SOL && cand < best) best <= cand;
      k <= k + 1'b1;
      used <= used + (TGT_W+1)'(v);
    end
    if (cmd.rd_total) begin
      i <= '0;
      rem <= target;
    end
    if (cmd.rb_init) begin
      k <= '0;
      used <= '0;
      pick <= '0;
    end
    if (cmd.rb_need) need <= rdata;
    if (cmd.rb_step) begin
      // k runs upward, the last match is the largest k
      if (rdata != NO_SOL && cand == need) pick <= k[STK_W-1:0];
      k <= k + 1'b1;
      used <= used + (TGT_W+1)'(v);
    end
    if (cmd.rb_done) begin
      rem <= rem - pick_amt[TGT_W-1:0];
      i <= i + 1'b1;
    end
    tot_rd <= cmd.rd_total;
    if (tot_rd) tot_q <= rdata;
  end

  assign sts.t_last   = (t == target);
  assign sts.i_zero   = (i == '0);
  assign sts.k_done   = (k > {1'b0, s}) || (used > {1'b0, t}) || (v == '0 && k != '0);
  assign sts.rb_hit   = (k > {1'b0, s}) || (used > {1'b0, rem}) || (v == '0);
  assign sts.rb_last  = (i == n - 1'b1);
  assign sts.no_sol   = (rdata == NO_SOL);
  assign sts.empty    = (n_sat == '0);
  assign sts.tgt_zero = (in_word.target_amount == '0);

  assign res.found       = 1'b1;
  assign res.result_slot = i[SLOT_W-1:0];
  assign res.used_count  = pick;
  assign res.total_coins = tot_q[TOT_W-1:0];
  assign res.last        = (i == n - 1'b1);
endmodule

### design/bcm_ctrl.sv
module bcm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bcm_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_sel,    // 1: datapath word, 0: fail word
  output logic               fail_found,
  output bcm_pkg::cmd_t      cmd,
  input  bcm_pkg::sts_t      sts
);
  import bcm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_BASE, S_CELL, S_KRD, S_KSTEP, S_WR, S_TOT, S_TOTW,
    S_RBI, S_RBW, S_RBS, S_RBR, S_EMIT, S_FAIL
  } state_t;
  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load  = in_valid && in_word.command == CMD_LOAD;
        cmd.start = in_valid && in_word.command == CMD_SOLVE;
      end
      S_BASE:  cmd.init_row = 1'b1;
      S_CELL:  cmd.cell_init = 1'b1;
      S_KSTEP: cmd.k_step = !sts.k_done;
      S_WR: begin
        cmd.cell_write = 1'b1;
        cmd.t_next = !sts.t_last;
        cmd.i_next = sts.t_last && !sts.i_zero;
      end
      S_TOT:  cmd.rd_total = 1'b1;
      S_RBI:  cmd.rb_init = 1'b1;
      S_RBW:  cmd.rb_need = 1'b1;
      S_RBR:  cmd.rb_read = 1'b1;
      S_RBS:  cmd.rb_step = !sts.rb_hit;
      S_EMIT: cmd.rb_done = out_ready && !sts.rb_last;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      out_sel <= 1'b0;
      fail_found <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid && in_word.command == CMD_SOLVE) begin
          if (sts.empty) begin
            fail_found <= sts.tgt_zero;
            out_sel <= 1'b0;
            out_valid <= 1'b1;
            state <= S_FAIL;
          end else state <= S_BASE;
        end
        S_BASE:  if (sts.t_last) state <= S_CELL;
        S_CELL:  state <= S_KRD;
        S_KRD:   state <= S_KSTEP;
        S_KSTEP: state <= sts.k_done ? S_WR : S_KRD;
        S_WR:    state <= (sts.t_last && sts.i_zero) ? S_TOT : S_CELL;
        S_TOT:   state <= S_TOTW;
        S_TOTW: begin
          if (sts.no_sol) begin
            fail_found <= 1'b0;
            out_sel <= 1'b0;
            out_valid <= 1'b1;
            state <= S_FAIL;
          end else state <= S_RBI;
        end
        S_RBI: state <= S_RBW;
        S_RBW: state <= S_RBS;
        S_RBS: if (sts.rb_hit) begin
          out_sel <= 1'b1;
          out_valid <= 1'b1;
          state <= S_EMIT;
        end else state <= S_RBR;
        S_RBR: state <= S_RBS;
        S_EMIT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= sts.rb_last ? S_IDLE : S_RBI;
        end
        S_FAIL: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### design/bounded_change_making_solver.sv
// bounded change maker, fewest coins under per-slot stock
// channels: in_ch carries load/solve words, out_ch carries result words
// cfg_we/cfg_data set slots_in_use (reset 0)
// a load is taken in idle and in_ch stays ready for the next word
// a solve with no slots in use gives its word in the cycle after it is taken
// otherwise a solve writes the base row for amounts 0 to target, then fills the
// slot by amount table one cell at a time, trying k coins per cell, over
// min(slots_in_use,16)*(target+1) cells, each k trial waiting on the
// registered table read; the total is then read from row 0 at the target
// rebuild: per slot, read need, then one table read per k tried, then its word
// one word at a time: in_ch is not ready during a solve
// reset returns the controller to idle; the table needs no clearing
// a stalled receiver holds the current result word until taken
module bounded_change_making_solver (
  input  logic clk,
  input  logic rst,
  bcm_if.sink   in_ch,
  bcm_if.source out_ch,
  input  logic cfg_we,
  input  logic [4:0] cfg_data
);
  import bcm_pkg::*;

  logic [NSL_W-1:0] slots_in_use;
  always_ff @(posedge clk) begin
    if (rst) slots_in_use <= '0;
    else if (cfg_we) slots_in_use <= cfg_data;
  end

  in_word_t in_word;
  out_word_t dp_res, o;
  cmd_t cmd;
  sts_t sts;
  logic out_sel, fail_found;
  assign in_word = in_ch.data;

  bcm_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_word,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_sel, .fail_found,
    .cmd, .sts
  );
  bcm_datapath u_dp (.clk, .cmd, .in_word, .slots_in_use, .sts, .res(dp_res));

  always_comb begin
    o = dp_res;
    if (!out_sel) begin
      o = '0;
      o.found = fail_found;
      o.last = 1'b1;
    end
  end
  assign out_ch.data = o;
endmodule

### design/bcm_checker.sv
module bcm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid, in_ready, out_valid, out_ready
);
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready during output");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid) else $error("input word withdrawn");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind bounded_change_making_solver bcm_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);

### dv/tb.sv
module tb;
  import bcm_pkg::*;

  localparam int UNREACH = 1 << 30;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [4:0] cfg_data;

  bcm_if #(.W($bits(in_word_t))) in_ch ();
  bcm_if #(.W($bits(out_word_t))) out_ch ();

  bounded_change_making_solver u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  // model state of the change maker
  logic [VAL_W-1:0] coin_val [MAX_SLOTS];
  logic [STK_W-1:0] coin_stk [MAX_SLOTS];
  logic [NSL_W-1:0] slots_cfg;
  int best_coins [MAX_SLOTS+1][MAX_TARGET+1];

  out_word_t owed_change[$];
  int errors = 0;
  bit quiet;
  bit stall_rx;
  event hold_go;

  typedef struct {
    bit is_cfg;
    logic [4:0] cfg;
    in_word_t w;
    bit typed;
    out_word_t exp;
  } row_t;
  row_t rows[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void push_single(bit fnd);
    out_word_t r;
    r = '0;
    r.found = fnd;
    r.last = 1'b1;
    owed_change.push_back(r);
  endfunction

  function automatic void solve_change(in_word_t w);
    int n, tgt, t, i, k, v, s, best, sub, rem, need, pick, total;
    out_word_t r;
    if (w.command == CMD_LOAD) begin
      coin_val[w.slot_index] = w.coin_value;
      coin_stk[w.slot_index] = w.coin_stock;
      return;
    end
    n = (int'(slots_cfg) > MAX_SLOTS) ? MAX_SLOTS : int'(slots_cfg);
    tgt = int'(w.target_amount);
    if (n == 0) begin
      push_single(tgt == 0);
      return;
    end
    for (t = 0; t <= tgt; t++) best_coins[n][t] = (t == 0) ? 0 : UNREACH;
    for (i = n - 1; i >= 0; i--) begin
      v = int'(coin_val[i]);
      s = int'(coin_stk[i]);
      for (t = 0; t <= tgt; t++) begin
        best = UNREACH;
        for (k = 0; k <= s; k++) begin
          if (k * v > t) break;
          sub = best_coins[i+1][t - k * v];
          if (sub != UNREACH && sub + k < best) best = sub + k;
          if (v == 0) break;
        end
        best_coins[i][t] = best;
      end
    end
    total = best_coins[0][tgt];
    if (total == UNREACH) begin
      push_single(1'b0);
      return;
    end
    rem = tgt;
    for (i = 0; i < n; i++) begin
      v = int'(coin_val[i]);
      s = int'(coin_stk[i]);
      need = best_coins[i][rem];
      pick = 0;
      if (v != 0) begin
        for (k = s; k >= 0; k--) begin
          if (k * v > rem) continue;
          sub = best_coins[i+1][rem - k * v];
          if (sub != UNREACH && sub + k == need) begin
            pick = k;
            break;
          end
        end
      end
      rem -= pick * v;
      r.found = 1'b1;
      r.result_slot = SLOT_W'(i);
      r.used_count = STK_W'(pick);
      r.total_coins = TOT_W'(total);
      r.last = (i + 1 == n);
      owed_change.push_back(r);
    end
  endfunction

  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 2);
  endfunction

  // long receiver hold-off, counted here
  initial begin
    stall_rx = 1'b0;
    @(hold_go);
    @(posedge clk);
    stall_rx <= 1'b1;
    repeat (400) @(posedge clk);
    stall_rx <= 1'b0;
  end

  // receiver: random ready, checks every result word
  int rx_idle;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_idle = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_word_t got, want;
        got = out_ch.data;
        if (owed_change.size() == 0) begin
          $error("unexpected result word slot=%0d", got.result_slot);
          errors++;
        end else begin
          want = owed_change.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0d actual %0d", want.found, got.found);
            errors++;
          end
          if (got.result_slot !== want.result_slot) begin
            $error("result_slot: expected %0d actual %0d",
                   want.result_slot, got.result_slot);
            errors++;
          end
          if (got.used_count !== want.used_count) begin
            $error("used_count: expected %0d actual %0d",
                   want.used_count, got.used_count);
            errors++;
          end
          if (got.total_coins !== want.total_coins) begin
            $error("total_coins: expected %0d actual %0d",
                   want.total_coins, got.total_coins);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d actual %0d", want.last, got.last);
            errors++;
          end
        end
      end
      if (stall_rx) begin
        out_ch.ready <= 1'b0;
      end else if (rx_idle > 0) begin
        out_ch.ready <= 1'b0;
        rx_idle--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_idle = pick_gap();
      end
    end
  end

  task automatic send_word(in_word_t w);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    solve_change(w);
  endtask

  // sender pauses until every owed word is back, then lets loads settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed_change.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_slots(logic [4:0] n);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    slots_cfg = n;
  endtask

  function automatic in_word_t load_word(int idx, int v, int s);
    in_word_t w;
    w = '0;
    w.command = CMD_LOAD;
    w.slot_index = SLOT_W'(idx);
    w.coin_value = VAL_W'(v);
    w.coin_stock = STK_W'(s);
    w.target_amount = TGT_W'($urandom());
    return w;
  endfunction

  function automatic in_word_t solve_word(int tgt);
    in_word_t w;
    w = '0;
    w.slot_index = SLOT_W'($urandom());
    w.coin_value = VAL_W'($urandom());
    w.coin_stock = STK_W'($urandom());
    w.command = CMD_SOLVE;
    w.target_amount = TGT_W'(tgt);
    return w;
  endfunction

  function automatic void add_cfg(logic [4:0] n);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.cfg = n;
    rows.push_back(r);
  endfunction

  function automatic void add_item(in_word_t w, bit typed, bit fnd);
    row_t r;
    r = '{default: '0};
    r.w = w;
    r.typed = typed;
    r.exp.found = fnd;
    r.exp.last = 1'b1;
    rows.push_back(r);
  endfunction

  initial begin
    int ph, nn, j, m, kind, tgt, items;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    quiet = 1'b0;
    slots_cfg = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: no slots, extremes, no solution, every coin spent
    add_item(solve_word(0), 1, 1);
    add_item(solve_word(5), 1, 0);
    add_item(solve_word(1023), 1, 0);
    add_cfg(3);
    add_item(load_word(0, 1023, 255), 0, 0);
    add_item(load_word(1, 0, 255), 0, 0);
    add_item(load_word(2, 1, 0), 0, 0);
    add_item(load_word(15, 512, 128), 0, 0);
    add_item(solve_word(0), 0, 0);
    add_item(solve_word(1023), 0, 0);
    add_item(solve_word(7), 1, 0);
    add_item(load_word(0, 3, 2), 0, 0);
    add_item(load_word(1, 2, 3), 0, 0);
    add_item(load_word(2, 1, 1), 0, 0);
    add_item(solve_word(7), 0, 0);
    add_item(solve_word(13), 0, 0);
    add_item(solve_word(14), 1, 0);
    add_item(load_word(1, 0, 5), 0, 0);
    add_item(solve_word(6), 0, 0);
    add_cfg(1);
    add_item(load_word(0, 1, 255), 0, 0);
    add_item(solve_word(255), 0, 0);
    add_item(solve_word(256), 1, 0);

    foreach (rows[r]) begin
      if (rows[r].is_cfg) begin
        write_slots(rows[r].cfg);
      end else if (rows[r].typed) begin
        send_word(rows[r].w);
        void'(owed_change.pop_back());
        owed_change.push_back(rows[r].exp);
      end else begin
        send_word(rows[r].w);
      end
    end

    // random phases: set slot count, load every used slot, then solve
    items = 0;
    ph = 0;
    while (items < 140) begin
      quiet = (ph % 3 == 2);
      kind = (ph == 1 || ph == 4) ? 1 : 0;
      if (ph == 1) nn = 31;
      else if (ph == 4) nn = $urandom_range(8, 16);
      else if ($urandom_range(0, 7) == 0) nn = 0;
      else nn = $urandom_range(1, 6);
      write_slots(5'(nn));
      m = (nn > MAX_SLOTS) ? MAX_SLOTS : nn;
      for (j = 0; j < m; j++) begin
        if (kind)
          send_word(load_word(j, $urandom_range(512, 1023), $urandom_range(0, 255)));
        else
          send_word(load_word(j, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 31),
                              ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 7)));
        items++;
      end
      // noise in slots that take no part in this phase
      if (m < MAX_SLOTS) begin
        send_word(load_word($urandom_range(m, 15), int'($urandom()), int'($urandom())));
        items++;
      end
      if (ph == 2) -> hold_go;
      for (j = 0; j < (kind ? 2 : $urandom_range(3, 6)); j++) begin
        if (kind) tgt = $urandom_range(0, 1023);
        else if ($urandom_range(0, 1) == 0 && m > 0) begin
          tgt = 0;
          for (int q = 0; q < m; q++)
            tgt += int'(coin_val[q]) *
                   int'($urandom_range(0, (coin_stk[q] > 3) ? 3 : coin_stk[q]));
          if (tgt > 63) tgt = 63;
        end else tgt = $urandom_range(0, 63);
        send_word(solve_word(tgt));
        items++;
        if (!kind && m > 0 && $urandom_range(0, 3) == 0) begin
          send_word(load_word($urandom_range(0, m - 1), $urandom_range(0, 31),
                              $urandom_range(0, 7)));
          items++;
        end
      end
      ph++;
    end

    in_ch.valid <= 1'b0;
    while (owed_change.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && owed_change.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(12 * 30000000);
    $display("FAILED: results differ");
    $finish;
  end
endmodule

### sim.f
design/bcm_pkg.sv
design/bcm_if.sv
design/bcm_datapath.sv
design/bcm_ctrl.sv
design/bounded_change_making_solver.sv
design/bcm_checker.sv
dv/tb.sv
